// ===== rtl/bbc_pkg.sv =====
package bbc_pkg;

  localparam int unsigned BufferCountDef = 32;
  localparam int unsigned BlockBitsDef   = 16;
  localparam int unsigned DeviceBitsDef  = 16;
  localparam int unsigned SearchMax      = 256;
  localparam logic [7:0]  RefMax         = 8'hFF;

  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_INVAL = 2'd2,
    OP_NOP   = 2'd3
  } bbc_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_BAD_PUT = 2'd2
  } bbc_status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] device;
    logic [15:0] block_number;
    logic        no_read;
    logic [4:0]  buffer_index;
    logic        mark_dirty;
    logic        lru_front;
    logic        write_immediate;
    logic        drop_tag;
  } bbc_req_t;

  typedef struct packed {
    logic [4:0]  buffer_index_res;
    logic        hit;
    logic        read_needed;
    logic        writeback_needed;
    logic [15:0] writeback_device;
    logic [15:0] writeback_block;
    logic [1:0]  status;
    logic [5:0]  buffers_in_use;
  } bbc_res_t;

  typedef struct packed {
    logic take_left;
    logic take_right;
    logic take_ins;
  } bbc_cell_ctrl_t;

  function automatic logic [8:0] first_set(input logic [SearchMax-1:0] v);
    logic [8:0] r;
    r = '0;
    for (int i = SearchMax - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, 8'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/block_buffer_cache_lru.sv =====
// Block buffer cache with LRU replacement. Each transaction (get, put, invalidate
// device or no operation) passes through the states S_IDLE, in which it is
// accepted and registered, S_LOOK, for the associative tag lookup and the scan of
// the LRU row for the first unreferenced buffer and for the released buffer's
// position, and S_EXEC, to update the buffer state and shift the LRU row of cells;
// S_EXEC waits while the previous result has not been taken. One transaction is
// processed at a time; the result register lets the next transaction be accepted
// while the previous result is still waiting. State is ready straight after reset.
module block_buffer_cache_lru #(
  parameter int unsigned BUFFER_COUNT = bbc_pkg::BufferCountDef,
  parameter int unsigned BLOCK_BITS   = bbc_pkg::BlockBitsDef,
  parameter int unsigned DEVICE_BITS  = bbc_pkg::DeviceBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bbc_pkg::bbc_req_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bbc_pkg::bbc_res_t out_o
);
  import bbc_pkg::*;

  localparam int unsigned IW = $clog2(BUFFER_COUNT);
  localparam int unsigned UW = $clog2(BUFFER_COUNT + 1);
  localparam logic [DEVICE_BITS-1:0] NoDev = '1;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC} state_e;

  state_e   state_q;
  bbc_req_t req_q;
  bbc_res_t res_q;
  logic     out_valid_q;

  logic [DEVICE_BITS-1:0] tag_dev_q [BUFFER_COUNT];
  logic [BLOCK_BITS-1:0]  tag_blk_q [BUFFER_COUNT];
  logic [7:0]             cnt_q     [BUFFER_COUNT];
  logic                   dirty_q   [BUFFER_COUNT];
  logic [UW-1:0]          in_use_q;

  logic          hit_q, got_q;
  logic [IW-1:0] hit_idx_q, vic_q, pos_q;

  logic [DEVICE_BITS-1:0] dev;
  logic [BLOCK_BITS-1:0]  blk;
  logic [IW-1:0]          bidx;
  logic                   bad_range;

  assign dev       = DEVICE_BITS'(req_q.device);
  assign blk       = BLOCK_BITS'(req_q.block_number);
  assign bidx      = IW'(req_q.buffer_index);
  assign bad_range = (32'(req_q.buffer_index) >= BUFFER_COUNT);

  logic [BUFFER_COUNT-1:0] free_vec, tag_hit, pos_free, pos_match;
  logic [IW-1:0]           cell_idx [BUFFER_COUNT];
  bbc_cell_ctrl_t          cell_ctrl [BUFFER_COUNT];

  always_comb begin
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      free_vec[i] = (cnt_q[i] == '0);
      tag_hit[i]  = (tag_dev_q[i] == dev) && (tag_blk_q[i] == blk) && (dev != NoDev);
    end
  end

  logic [8:0] hit_find, free_find, pos_find;
  assign hit_find  = first_set(SearchMax'(tag_hit));
  assign free_find = first_set(SearchMax'(pos_free));
  assign pos_find  = first_set(SearchMax'(pos_match));

  logic [IW-1:0] sel;
  logic          commit, is_get, is_put, put_ok, release_b;
  logic [7:0]    cnt_sel;

  assign is_get    = (req_q.opcode == OP_GET);
  assign is_put    = (req_q.opcode == OP_PUT);
  assign sel       = hit_q ? hit_idx_q : (is_get ? vic_q : bidx);
  assign cnt_sel   = cnt_q[sel];
  assign put_ok    = is_put && !bad_range && (cnt_sel != '0);
  assign release_b = put_ok && (cnt_sel == 8'd1);
  assign commit    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  for (genvar p = 0; p < BUFFER_COUNT; p++) begin : g_row
    logic [IW-1:0] left_w, right_w;
    if (p == 0) begin : g_l0
      assign left_w = cell_idx[p];
    end else begin : g_l
      assign left_w = cell_idx[p-1];
    end
    if (p == BUFFER_COUNT - 1) begin : g_rn
      assign right_w = cell_idx[p];
    end else begin : g_r
      assign right_w = cell_idx[p+1];
    end

    always_comb begin
      cell_ctrl[p] = '0;
      if (commit && release_b) begin
        if (req_q.lru_front) begin
          cell_ctrl[p].take_ins  = (p == 0);
          cell_ctrl[p].take_left = (p != 0) && (IW'(p) <= pos_q);
        end else begin
          cell_ctrl[p].take_ins   = (p == BUFFER_COUNT - 1);
          cell_ctrl[p].take_right = (p != BUFFER_COUNT - 1) && (IW'(p) >= pos_q);
        end
      end
    end

    bbc_cell #(
      .BUFFER_COUNT(BUFFER_COUNT),
      .IW          (IW),
      .RESET_IDX   (IW'(p))
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl[p]),
      .left_i    (left_w),
      .right_i   (right_w),
      .ins_i     (bidx),
      .target_i  (bidx),
      .free_vec_i(free_vec),
      .idx_o     (cell_idx[p]),
      .free_o    (pos_free[p]),
      .match_o   (pos_match[p])
    );
  end

  bbc_res_t res_d;
  logic [DEVICE_BITS-1:0] dev_new;
  logic [7:0]             cnt_new;
  logic                   dirty_new;
  logic [UW-1:0]          in_use_new;

  always_comb begin
    res_d      = '0;
    dev_new    = tag_dev_q[sel];
    cnt_new    = cnt_sel;
    dirty_new  = dirty_q[sel];
    in_use_new = in_use_q;
    case (req_q.opcode)
      OP_GET: begin
        if (hit_q) begin
          if (cnt_sel == '0) in_use_new = in_use_q + 1'b1;
          if (cnt_sel != RefMax) cnt_new = cnt_sel + 8'd1;
          res_d.buffer_index_res = 5'(hit_idx_q);
          res_d.hit              = 1'b1;
        end else if (!got_q) begin
          res_d.status = ST_NO_FREE;
        end else begin
          if (dirty_q[sel] && tag_dev_q[sel] != NoDev) begin
            res_d.writeback_needed = 1'b1;
            res_d.writeback_device = 16'(tag_dev_q[sel]);
            res_d.writeback_block  = 16'(tag_blk_q[sel]);
            dirty_new              = 1'b0;
          end
          dev_new    = dev;
          cnt_new    = 8'd1;
          in_use_new = in_use_q + 1'b1;
          if (dev != NoDev && !req_q.no_read) begin
            res_d.read_needed = 1'b1;
            dirty_new         = 1'b0;
          end
          res_d.buffer_index_res = 5'(vic_q);
        end
      end
      OP_PUT: begin
        if (!put_ok) begin
          res_d.status = ST_BAD_PUT;
        end else begin
          res_d.buffer_index_res = 5'(bidx);
          dirty_new = dirty_q[sel] | req_q.mark_dirty;
          cnt_new   = cnt_sel - 8'd1;
          if (release_b) begin
            if (in_use_q != '0) in_use_new = in_use_q - 1'b1;
            if (req_q.write_immediate && dirty_new && tag_dev_q[sel] != NoDev) begin
              res_d.writeback_needed = 1'b1;
              res_d.writeback_device = 16'(tag_dev_q[sel]);
              res_d.writeback_block  = 16'(tag_blk_q[sel]);
              dirty_new              = 1'b0;
            end
            if (req_q.drop_tag) dev_new = NoDev;
          end
        end
      end
      default: begin
      end
    endcase
    res_d.buffers_in_use = 6'(in_use_new);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        tag_dev_q[i] <= NoDev;
        tag_blk_q[i] <= '0;
        cnt_q[i]     <= '0;
        dirty_q[i]   <= 1'b0;
      end
      in_use_q <= '0;
    end else if (commit) begin
      in_use_q <= in_use_new;
      if (req_q.opcode == OP_INVAL) begin
        for (int i = 0; i < BUFFER_COUNT; i++) begin
          if (tag_dev_q[i] == dev) tag_dev_q[i] <= NoDev;
        end
      end else if ((is_get && (hit_q || got_q)) || put_ok) begin
        tag_dev_q[sel] <= dev_new;
        tag_blk_q[sel] <= (is_get && !hit_q) ? blk : tag_blk_q[sel];
        cnt_q[sel]     <= cnt_new;
        dirty_q[sel]   <= dirty_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      res_q       <= '0;
      hit_q       <= 1'b0;
      got_q       <= 1'b0;
      hit_idx_q   <= '0;
      vic_q       <= '0;
      pos_q       <= '0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_i;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit_q     <= is_get && hit_find[8];
          hit_idx_q <= IW'(hit_find[7:0]);
          got_q     <= free_find[8];
          vic_q     <= cell_idx[IW'(free_find[7:0])];
          pos_q     <= IW'(pos_find[7:0]);
          state_q   <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) begin
            res_q   <= res_d;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

endmodule

// ===== rtl/bbc_cell.sv =====
module bbc_cell #(
  parameter int unsigned BUFFER_COUNT = bbc_pkg::BufferCountDef,
  parameter int unsigned IW           = $clog2(BUFFER_COUNT),
  parameter logic [IW-1:0] RESET_IDX  = '0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bbc_pkg::bbc_cell_ctrl_t ctrl_i,
  input  logic [IW-1:0]          left_i,
  input  logic [IW-1:0]          right_i,
  input  logic [IW-1:0]          ins_i,
  input  logic [IW-1:0]          target_i,
  input  logic [BUFFER_COUNT-1:0] free_vec_i,
  output logic [IW-1:0]          idx_o,
  output logic                   free_o,
  output logic                   match_o
);
  import bbc_pkg::*;

  logic [IW-1:0] idx_q, idx_d;

  always_comb begin
    idx_d = idx_q;
    if (ctrl_i.take_ins) begin
      idx_d = ins_i;
    end else if (ctrl_i.take_left) begin
      idx_d = left_i;
    end else if (ctrl_i.take_right) begin
      idx_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= RESET_IDX;
    end else begin
      idx_q <= idx_d;
    end
  end

  assign idx_o   = idx_q;
  assign free_o  = free_vec_i[idx_q];
  assign match_o = (idx_q == target_i);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import bbc_pkg::*;

  localparam int NBUF = 32;
  localparam logic [15:0] NoDev = 16'hFFFF;
  localparam int CycleLimit = 400000;
  localparam int ReqBits = $bits(bbc_req_t);

  class cache_scoreboard;
    logic [15:0] tag_dev[NBUF];
    logic [15:0] tag_blk[NBUF];
    logic [7:0]  refs[NBUF];
    bit          dirty[NBUF];
    logic [4:0]  lru[NBUF];
    int          in_use;
    bbc_res_t    pending[$];
    int          errors;

    function void clear();
      for (int i = 0; i < NBUF; i++) begin
        tag_dev[i] = NoDev;
        tag_blk[i] = '0;
        refs[i] = '0;
        dirty[i] = 0;
        lru[i] = 5'(i);
      end
      in_use = 0;
      errors = 0;
    endfunction

    function void reorder(int idx, bit to_front);
      int pos;
      pos = 0;
      for (int i = 0; i < NBUF; i++) if (lru[i] == 5'(idx)) begin pos = i; break; end
      if (to_front) begin
        for (int i = pos; i > 0; i--) lru[i] = lru[i-1];
        lru[0] = 5'(idx);
      end else begin
        for (int i = pos; i < NBUF - 1; i++) lru[i] = lru[i+1];
        lru[NBUF-1] = 5'(idx);
      end
    endfunction

    function void note_request(bbc_req_t q);
      bbc_res_t r;
      bit found, got;
      int v, b;
      r = '0;
      found = 0;
      got = 0;
      v = 0;
      case (bbc_op_e'(q.opcode))
        OP_GET: begin
          if (q.device != NoDev) begin
            for (int i = 0; i < NBUF; i++) begin
              if (tag_dev[i] == q.device && tag_blk[i] == q.block_number) begin
                if (refs[i] == 0) in_use++;
                if (refs[i] != RefMax) refs[i]++;
                r.buffer_index_res = 5'(i);
                r.hit = 1;
                found = 1;
                break;
              end
            end
          end
          if (!found) begin
            for (int i = 0; i < NBUF; i++) begin
              if (refs[lru[i]] == 0) begin v = lru[i]; got = 1; break; end
            end
            if (!got) r.status = ST_NO_FREE;
            else begin
              if (dirty[v] && tag_dev[v] != NoDev) begin
                r.writeback_needed = 1;
                r.writeback_device = tag_dev[v];
                r.writeback_block = tag_blk[v];
                dirty[v] = 0;
              end
              tag_dev[v] = q.device;
              tag_blk[v] = q.block_number;
              refs[v] = 1;
              in_use++;
              if (q.device != NoDev && !q.no_read) begin
                r.read_needed = 1;
                dirty[v] = 0;
              end
              r.buffer_index_res = 5'(v);
            end
          end
        end
        OP_PUT: begin
          b = q.buffer_index;
          if (refs[b] == 0) r.status = ST_BAD_PUT;
          else begin
            r.buffer_index_res = 5'(b);
            if (q.mark_dirty) dirty[b] = 1;
            refs[b]--;
            if (refs[b] == 0) begin
              if (in_use > 0) in_use--;
              reorder(b, q.lru_front);
              if (q.write_immediate && dirty[b] && tag_dev[b] != NoDev) begin
                r.writeback_needed = 1;
                r.writeback_device = tag_dev[b];
                r.writeback_block = tag_blk[b];
                dirty[b] = 0;
              end
              if (q.drop_tag) tag_dev[b] = NoDev;
            end
          end
        end
        OP_INVAL: begin
          for (int i = 0; i < NBUF; i++) if (tag_dev[i] == q.device) tag_dev[i] = NoDev;
        end
        default: ;
      endcase
      r.buffers_in_use = 6'(in_use);
      pending.push_back(r);
    endfunction

    function void check_result(bbc_res_t a);
      bbc_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", a);
        return;
      end
      e = pending.pop_front();
      if (a.buffer_index_res !== e.buffer_index_res || a.hit !== e.hit ||
          a.read_needed !== e.read_needed || a.writeback_needed !== e.writeback_needed ||
          a.writeback_device !== e.writeback_device ||
          a.writeback_block !== e.writeback_block || a.status !== e.status ||
          a.buffers_in_use !== e.buffers_in_use) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
      end
    endfunction
  endclass

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     in_valid_i = 0;
  logic     in_ready_o;
  bbc_req_t in_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 0;
  bbc_res_t out_o;

  cache_scoreboard sb = new();
  bit   steady;
  int   cycles;
  bbc_req_t held_bufs[$];

  block_buffer_cache_lru dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_o);
      out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** block_buffer_cache_lru: FAILED **");
      $finish;
    end
  end

  task automatic send(bbc_req_t q);
    bit idle;
    idle = !steady && ($urandom_range(99) < 23);
    if (idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!steady && $urandom_range(99) < 23);
    end
    in_valid_i <= 1'b1;
    in_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(q);
  endtask

  function automatic bbc_req_t rand_req();
    bbc_req_t q;
    q = bbc_req_t'(ReqBits'({$urandom, $urandom}));
    q.device = 16'($urandom_range(3));
    if ($urandom_range(19) == 0) q.device = NoDev;
    if ($urandom_range(19) == 0) q.device = 16'($urandom);
    q.block_number = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    case ($urandom_range(19))
      0: q.opcode = OP_INVAL;
      1: q.opcode = OP_NOP;
      2, 3, 4, 5, 6, 7, 8, 9: q.opcode = OP_GET;
      default: q.opcode = OP_PUT;
    endcase
    if (q.opcode == OP_PUT && $urandom_range(9) != 0) begin
      for (int t = 0; t < 8; t++) begin
        q.buffer_index = 5'($urandom);
        if (sb.refs[q.buffer_index] != 0) break;
      end
    end
    q.lru_front = $urandom_range(3) == 0;
    q.drop_tag = $urandom_range(7) == 0;
    return q;
  endfunction

  initial begin
    bbc_req_t q;
    sb.clear();
    steady = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    q = '0;
    q.opcode = OP_NOP; send(q);
    q.opcode = OP_PUT; q.buffer_index = 5'd31; send(q);
    q = '0; q.opcode = OP_GET; q.device = 16'hFFFE; q.block_number = 16'hFFFF; send(q);
    q.no_read = 1; q.device = 16'h0000; q.block_number = 16'h0000; send(q);
    q.no_read = 0; send(q);
    q.device = NoDev; send(q);
    q = '0; q.opcode = OP_PUT; q.buffer_index = 5'd0; q.mark_dirty = 1; send(q);
    q.write_immediate = 1; send(q);
    q = '0; q.opcode = OP_PUT; q.buffer_index = 5'd1; q.mark_dirty = 1;
    q.write_immediate = 1; q.lru_front = 1; q.drop_tag = 1; send(q);
    q = '0; q.opcode = OP_INVAL; q.device = 16'hFFFE; send(q);
    for (int i = 0; i < 34; i++) begin
      q = '0; q.opcode = OP_GET; q.device = 16'd7; q.block_number = 16'(i); send(q);
    end
    for (int i = 0; i < 260; i++) begin
      q = '0; q.opcode = OP_GET; q.device = 16'd7; q.block_number = 16'd3; send(q);
    end
    for (int i = 0; i < NBUF; i++) begin
      q = '0; q.opcode = OP_PUT; q.buffer_index = 5'(i); q.mark_dirty = i[0];
      q.lru_front = i[1]; send(q);
    end
    for (int i = 0; i < 260; i++) begin
      q = '0; q.opcode = OP_PUT; q.buffer_index = 5'd3; q.mark_dirty = 1;
      q.write_immediate = 1; send(q);
    end
    for (int i = 0; i < 554; i++) begin
      steady = (i >= 250 && i < 350);
      send(rand_req());
    end
    steady = 0;
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("** block_buffer_cache_lru: PASSED **");
    else $display("** block_buffer_cache_lru: FAILED **");
    $finish;
  end
endmodule
